FILE: sv/csf_pkg.sv
// shared types, constants and the arctangent table for the cordic sine/cosine block
`timescale 1ns / 1ps

package csf_pkg;

   localparam int WORK_FRAC  = 30;
   localparam int ANGLE_FRAC = 12;
   localparam int ANGLE_SHIFT = WORK_FRAC - ANGLE_FRAC;

   // rotation vector width: magnitude stays near 2^30, headroom for one add
   localparam int VEC_WIDTH = 34;
   // minimum angle accumulator width that holds the fold constants
   localparam int PHI_MIN_WIDTH = 36;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_ITERATIONS = 1'b0;

   localparam int ITER_WIDTH = 5;
   localparam logic [ITER_WIDTH-1:0] ITER_RESET = 5'd16;

   localparam logic signed [PHI_MIN_WIDTH-1:0] PI_Q            = 36'sd3373259426;
   localparam logic signed [PHI_MIN_WIDTH-1:0] HALF_PI_Q       = 36'sd1686629713;
   localparam logic signed [PHI_MIN_WIDTH-1:0] THREE_HALF_PI_Q = 36'sd5059889139;
   localparam logic signed [PHI_MIN_WIDTH-1:0] TWO_PI_Q        = 36'sd6746518852;

   localparam logic signed [VEC_WIDTH-1:0] GAIN_START = 34'sd652032874;

   typedef struct packed {
      logic neg;
      logic in_range;
   } ctl_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] n);
      logic [31:0] v;
      case (n)
         5'd0:  v = 32'd843314856;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043836;
         5'd3:  v = 32'd133525158;
         5'd4:  v = 32'd67021686;
         5'd5:  v = 32'd33543515;
         5'd6:  v = 32'd16775850;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194282;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048575;
         5'd11: v = 32'd524287;
         5'd12: v = 32'd262143;
         5'd13: v = 32'd131071;
         5'd14: v = 32'd65535;
         5'd15: v = 32'd32767;
         5'd16: v = 32'd16383;
         5'd17: v = 32'd8191;
         5'd18: v = 32'd4095;
         5'd19: v = 32'd2047;
         5'd20: v = 32'd1023;
         5'd21: v = 32'd511;
         5'd22: v = 32'd255;
         5'd23: v = 32'd127;
         5'd24: v = 32'd63;
         5'd25: v = 32'd31;
         5'd26: v = 32'd15;
         5'd27: v = 32'd7;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/csf_csr.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps

module csf_csr
   import csf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [ITER_WIDTH-1:0]     iterations
);

   logic [ITER_WIDTH-1:0] iter_ff;
   logic [ITER_WIDTH-1:0] iter_in;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_ITERATIONS);

   always_comb begin
      iter_in = iter_ff;
      if (wr_en) begin
         iter_in = csr_pwdata[ITER_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= ITER_RESET;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_ITERATIONS) begin
         csr_prdata = {{(CSR_DATA_WIDTH-ITER_WIDTH){1'b0}}, iter_ff};
      end
   end

   assign iterations = iter_ff;

endmodule

FILE: sv/csf_fold.sv
// input stage: scales the angle and folds it into the cordic convergence band
`timescale 1ns / 1ps

module csf_fold
   import csf_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16,
   parameter int PW = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ANGLE_WIDTH-1:0] in_angle,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [PW-1:0]          out_phi,
   output ctl_type                       out_ctl
);

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [PW-1:0] phi_ff;
   logic signed [PW-1:0] phi_in;
   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic signed [PW-1:0] phi_raw;
   logic signed [PW-1:0] pi_w;
   logic signed [PW-1:0] half_pi_w;
   logic signed [PW-1:0] three_half_pi_w;
   logic signed [PW-1:0] two_pi_w;

   assign pi_w            = PW'(PI_Q);
   assign half_pi_w       = PW'(HALF_PI_Q);
   assign three_half_pi_w = PW'(THREE_HALF_PI_Q);
   assign two_pi_w        = PW'(TWO_PI_Q);

   assign phi_raw = PW'(in_angle) <<< ANGLE_SHIFT;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      phi_in = phi_raw;
      ctl_in.neg = 1'b0;
      ctl_in.in_range = 1'b1;
      if (phi_raw >= three_half_pi_w) begin
         phi_in = phi_raw - two_pi_w;
      end else if (phi_raw > half_pi_w) begin
         phi_in = phi_raw - pi_w;
         ctl_in.neg = 1'b1;
      end else if (phi_raw > -pi_w && phi_raw <= -half_pi_w) begin
         phi_in = phi_raw + pi_w;
         ctl_in.neg = 1'b1;
      end else if (phi_raw <= -pi_w) begin
         ctl_in.in_range = 1'b0;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         phi_ff <= phi_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_phi   = phi_ff;
   assign out_ctl   = ctl_ff;

endmodule

FILE: sv/csf_rot_stage.sv
// one cordic micro-rotation with its pipeline register
`timescale 1ns / 1ps

module csf_rot_stage
   import csf_pkg::*;
#(
   parameter int STAGE = 0,
   parameter int PW = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rot_en,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [PW-1:0]        in_phi,
   input  logic signed [VEC_WIDTH-1:0] in_x,
   input  logic signed [VEC_WIDTH-1:0] in_y,
   input  ctl_type                     in_ctl,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [PW-1:0]        out_phi,
   output logic signed [VEC_WIDTH-1:0] out_x,
   output logic signed [VEC_WIDTH-1:0] out_y,
   output ctl_type                     out_ctl
);

   logic                        valid_ff;
   logic                        valid_in;
   logic signed [PW-1:0]        phi_ff;
   logic signed [PW-1:0]        phi_in;
   logic signed [VEC_WIDTH-1:0] x_ff;
   logic signed [VEC_WIDTH-1:0] x_in;
   logic signed [VEC_WIDTH-1:0] y_ff;
   logic signed [VEC_WIDTH-1:0] y_in;
   ctl_type                     ctl_ff;
   logic signed [VEC_WIDTH-1:0] dx;
   logic signed [VEC_WIDTH-1:0] dy;
   logic signed [PW-1:0]        step;

   assign dx   = in_y >>> STAGE;
   assign dy   = in_x >>> STAGE;
   assign step = signed'({{(PW-32){1'b0}}, atan_q30(5'(STAGE))});

   always_comb begin
      phi_in = in_phi;
      x_in   = in_x;
      y_in   = in_y;
      if (rot_en) begin
         if (in_phi < 0) begin
            phi_in = in_phi + step;
            x_in   = in_x + dx;
            y_in   = in_y - dy;
         end else begin
            phi_in = in_phi - step;
            x_in   = in_x - dx;
            y_in   = in_y + dy;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         phi_ff <= phi_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_phi   = phi_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ctl   = ctl_ff;

endmodule

FILE: sv/csf_round.sv
// output stage: rounding, saturation, sign restore and result register
`timescale 1ns / 1ps

module csf_round
   import csf_pkg::*;
#(
   parameter int RESULT_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [VEC_WIDTH-1:0]    in_x,
   input  logic signed [VEC_WIDTH-1:0]    in_y,
   input  ctl_type                        in_ctl,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [RESULT_WIDTH-1:0] rsp_sine,
   output logic signed [RESULT_WIDTH-1:0] rsp_cosine,
   output logic                           rsp_in_range
);

   localparam int RF    = RESULT_WIDTH - 2;
   localparam int SH    = WORK_FRAC - RF;
   localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
   localparam int EW    = VEC_WIDTH + 1;

   logic                           valid_ff;
   logic                           valid_in;
   logic signed [RESULT_WIDTH-1:0] sine_ff;
   logic signed [RESULT_WIDTH-1:0] sine_in;
   logic signed [RESULT_WIDTH-1:0] cosine_ff;
   logic signed [RESULT_WIDTH-1:0] cosine_in;
   logic                           in_range_ff;

   function automatic logic signed [RESULT_WIDTH-1:0] conv(
      input logic signed [VEC_WIDTH-1:0] v,
      input ctl_type                     ctl
   );
      logic signed [EW-1:0] ext;
      logic signed [EW-1:0] rnd;
      logic signed [EW-1:0] lim;
      logic signed [EW-1:0] r;
      ext = EW'(v);
      rnd = (SH > 0) ? (EW'(1) << SH_M1) : '0;
      lim = EW'(1) << RF;
      r = (ext + rnd) >>> SH;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      if (ctl.neg) begin
         r = -r;
      end
      if (!ctl.in_range) begin
         r = '0;
      end
      return r[RESULT_WIDTH-1:0];
   endfunction

   assign sine_in   = conv(in_y, in_ctl);
   assign cosine_in = conv(in_x, in_ctl);

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sine_ff     <= sine_in;
         cosine_ff   <= cosine_in;
         in_range_ff <= in_ctl.in_range;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_sine     = sine_ff;
   assign rsp_cosine   = cosine_ff;
   assign rsp_in_range = in_range_ff;

endmodule

FILE: sv/cordic_sine_cosine_fixed.sv
// top level of the pipelined cordic sine/cosine block
`timescale 1ns / 1ps

// Streaming sine/cosine of a fixed-point angle (12 fraction bits, radians) by
// rotation-mode CORDIC. The angle is folded into (-pi/2, pi/2], but angles above
// 5pi/2 land above pi/2; it then passes the fold register, one register stage
// per micro-rotation (TABLE_DEPTH stages) and a rounding stage. One angle is
// accepted every cycle unless the result side holds rsp_ready low.
// Results carry RESULT_WIDTH-2 fraction bits and saturate to +-1.0. The
// iterations register (reset 16, capped at TABLE_DEPTH) selects how many stages
// rotate; the rest pass the vector unchanged. Write it only while no angle is in
// flight. Angles at or below -pi return zeros with rsp_in_range low.

module cordic_sine_cosine_fixed
   import csf_pkg::*;
#(
   parameter int TABLE_DEPTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int RESULT_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [ANGLE_WIDTH-1:0]  req_angle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [RESULT_WIDTH-1:0] rsp_sine,
   output logic signed [RESULT_WIDTH-1:0] rsp_cosine,
   output logic                           rsp_in_range,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                           csr_pready
);

   localparam int PW = (ANGLE_WIDTH + ANGLE_SHIFT + 2 > PHI_MIN_WIDTH) ?
                       ANGLE_WIDTH + ANGLE_SHIFT + 2 : PHI_MIN_WIDTH;

   logic [ITER_WIDTH-1:0]       iterations;
   logic                        valid_s [TABLE_DEPTH+1];
   logic                        ready_s [TABLE_DEPTH+1];
   logic signed [PW-1:0]        phi_s   [TABLE_DEPTH+1];
   logic signed [VEC_WIDTH-1:0] x_s     [TABLE_DEPTH+1];
   logic signed [VEC_WIDTH-1:0] y_s     [TABLE_DEPTH+1];
   ctl_type                     ctl_s   [TABLE_DEPTH+1];

   csf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .iterations  (iterations)
   );

   csf_fold #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .PW          (PW)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_angle  (req_angle),
      .out_valid (valid_s[0]),
      .out_ready (ready_s[0]),
      .out_phi   (phi_s[0]),
      .out_ctl   (ctl_s[0])
   );

   assign x_s[0] = GAIN_START;
   assign y_s[0] = '0;

   for (genvar n = 0; n < TABLE_DEPTH; n++) begin : g_rot
      logic rot_en;
      assign rot_en = iterations > ITER_WIDTH'(n);

      csf_rot_stage #(
         .STAGE (n),
         .PW    (PW)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .rot_en    (rot_en),
         .in_valid  (valid_s[n]),
         .in_ready  (ready_s[n]),
         .in_phi    (phi_s[n]),
         .in_x      (x_s[n]),
         .in_y      (y_s[n]),
         .in_ctl    (ctl_s[n]),
         .out_valid (valid_s[n+1]),
         .out_ready (ready_s[n+1]),
         .out_phi   (phi_s[n+1]),
         .out_x     (x_s[n+1]),
         .out_y     (y_s[n+1]),
         .out_ctl   (ctl_s[n+1])
      );
   end

   csf_round #(
      .RESULT_WIDTH (RESULT_WIDTH)
   ) u_round (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (valid_s[TABLE_DEPTH]),
      .in_ready     (ready_s[TABLE_DEPTH]),
      .in_x         (x_s[TABLE_DEPTH]),
      .in_y         (y_s[TABLE_DEPTH]),
      .in_ctl       (ctl_s[TABLE_DEPTH]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sine     (rsp_sine),
      .rsp_cosine   (rsp_cosine),
      .rsp_in_range (rsp_in_range)
   );

endmodule

FILE: sv/csf_checker.sv
// port-level checks for the cordic sine/cosine block and their bind
`timescale 1ns / 1ps

module csf_checker #(
   parameter int RESULT_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [RESULT_WIDTH-1:0] rsp_sine,
   input logic signed [RESULT_WIDTH-1:0] rsp_cosine,
   input logic                           rsp_in_range
);

   localparam logic signed [RESULT_WIDTH-1:0] LIM = RESULT_WIDTH'(1) << (RESULT_WIDTH - 2);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sine) && $stable(rsp_cosine)
                                  && $stable(rsp_in_range))
      else $error("stalled result beat changed");

   // input backpressure only when the result side is stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

   // out-of-range angles give zeros
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_sine == '0 && rsp_cosine == '0)
      else $error("out-of-range beat with nonzero result");

   // results stay within +-1.0
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sine <= LIM && rsp_sine >= -LIM && rsp_cosine <= LIM
                    && rsp_cosine >= -LIM)
      else $error("result beyond saturation limit");

endmodule

bind cordic_sine_cosine_fixed csf_checker #(
   .RESULT_WIDTH (RESULT_WIDTH)
) u_csf_checker (.*);

FILE: tb/testbench.sv
// self-checking testbench for the cordic sine/cosine block: directed, register and random angles
`timescale 1ns / 1ps

module testbench;
   import csf_pkg::*;

   localparam int ANGLE_W  = 16;
   localparam int RESULT_W = 16;
   localparam int STAGES   = 16;
   localparam int LATENCY  = STAGES + 2;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ANGLES = 500;

   localparam longint PI_Q30       = 64'sd3373259426;
   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam longint TH_PI_Q30    = 64'sd5059889139;
   localparam longint TWO_PI_Q30   = 64'sd6746518852;
   localparam longint START_GAIN   = 64'sd652032874;
   localparam longint UNITY        = 64'sd16384;

   localparam logic [CSR_ADDR_WIDTH-1:0] ITER_ADDR =
      CSR_ADDR_WIDTH'(4 * int'(CSR_IDX_ITERATIONS));

   typedef logic signed [ANGLE_W-1:0] angle_t;

   typedef struct packed {
      logic signed [RESULT_W-1:0] sine;
      logic signed [RESULT_W-1:0] cosine;
      logic                       in_range;
   } trig_t;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   angle_t                    req_angle;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [RESULT_W-1:0] rsp_sine;
   logic signed [RESULT_W-1:0] rsp_cosine;
   logic                      rsp_in_range;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   longint atan_q30_tab [0:15] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767
   };

   trig_t       pending_trig[$];
   logic [4:0]  iter_setting;
   int          failures;
   int          angles_sent;
   int          results_seen;
   int          iter_writes;
   int          cycles;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          long_hold_request;

   cordic_sine_cosine_fixed dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_angle(req_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sine(rsp_sine),
      .rsp_cosine(rsp_cosine),
      .rsp_in_range(rsp_in_range),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   function automatic longint round_to_result(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > UNITY) r = UNITY;
      if (r < -UNITY) r = -UNITY;
      return r;
   endfunction

   function automatic trig_t predict_trig(angle_t angle, logic [4:0] iters);
      trig_t  res;
      longint phi, x, y, t, dx, dy, s_out, c_out;
      bit     flip;
      int     count;
      flip = 1'b0;
      phi = longint'(angle) * 64'sd262144;
      if (phi >= TH_PI_Q30) begin
         phi = phi - TWO_PI_Q30;
      end else if (phi > HALF_PI_Q30) begin
         phi = phi - PI_Q30;
         flip = 1'b1;
      end else if (phi > -PI_Q30 && phi <= -HALF_PI_Q30) begin
         phi = phi + PI_Q30;
         flip = 1'b1;
      end else if (phi <= -PI_Q30) begin
         res = '0;
         return res;
      end
      count = (iters > STAGES) ? STAGES : int'(iters);
      x = START_GAIN;
      y = 0;
      for (int n = 0; n < count; n++) begin
         dx = y >>> n;
         dy = x >>> n;
         if (phi < 0) begin
            phi = phi + atan_q30_tab[n];
            t = x + dx;
            y = y - dy;
         end else begin
            phi = phi - atan_q30_tab[n];
            t = x - dx;
            y = y + dy;
         end
         x = t;
      end
      s_out = round_to_result(y);
      c_out = round_to_result(x);
      if (flip) begin
         s_out = -s_out;
         c_out = -c_out;
      end
      res.sine = s_out[RESULT_W-1:0];
      res.cosine = c_out[RESULT_W-1:0];
      res.in_range = 1'b1;
      return res;
   endfunction

   function automatic angle_t random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return angle_t'($urandom_range(0, 65535));
      if (pick < 8) return angle_t'($urandom_range(0, 32767) - 12867);
      case ($urandom_range(0, 5))
         0: return angle_t'(6433 + $urandom_range(0, 6) - 3);
         1: return angle_t'(19301 + $urandom_range(0, 6) - 3);
         2: return angle_t'(-6433 + $urandom_range(0, 6) - 3);
         3: return angle_t'(-12867 + $urandom_range(0, 6) - 3);
         4: return angle_t'(12868 + $urandom_range(0, 6) - 3);
         default: return angle_t'($urandom_range(0, 16) - 8);
      endcase
   endfunction

   task automatic record_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
   endtask

   // one angle beat; caller is aligned just after a rising edge
   task automatic send_angle(angle_t angle);
      int gap;
      req_valid <= 1'b1;
      req_angle <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_trig.push_back(predict_trig(angle, iter_setting));
      angles_sent++;
      gap = (req_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_trig.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_iterations(logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ITER_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      iter_setting = value[4:0];
      iter_writes++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[4:0] !== iter_setting)
         record_failure($sformatf("iterations readback expected %0d got %0d",
                                  iter_setting, readback[4:0]));
   endtask

   task automatic test_fold_boundaries();
      angle_t edges[$];
      edges = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                16'sd6433, 16'sd6434, 16'sd12867, 16'sd12868, 16'sd19301,
                16'sd19302, 16'sd25736, -16'sd6433, -16'sd6434, -16'sd12867,
                -16'sd12868, -16'sd12869, -16'sd20000, 16'sd3217, -16'sd3217};
      foreach (edges[i]) send_angle(edges[i]);
      wait_results_drained();
   endtask

   task automatic test_iteration_counts();
      logic [4:0] counts[$];
      counts = '{5'd0, 5'd1, 5'd2, 5'd15, 5'd17, 5'd31, 5'd8, 5'd16};
      foreach (counts[i]) begin
         write_iterations(CSR_DATA_WIDTH'(counts[i]));
         send_angle(16'sd0);
         send_angle(16'sd32767);
         send_angle(-16'sd12867);
         repeat (5) send_angle(random_angle());
         wait_results_drained();
      end
   endtask

   task automatic test_output_backpressure();
      long_hold_request = 1'b1;
      req_idle_on = 1'b0;
      repeat (60) send_angle(random_angle());
      wait_results_drained();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_stream();
      for (int seg = 0; seg < 5; seg++) begin
         if (seg == 4) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         if (seg != 0) write_iterations(CSR_DATA_WIDTH'($urandom_range(0, 31)));
         else write_iterations(CSR_DATA_WIDTH'(ITER_RESET));
         repeat (RANDOM_ANGLES / 5) send_angle(random_angle());
         wait_results_drained();
      end
   endtask

   // result side: random stalls, plus one long hold on request
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      trig_t got;
      trig_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_sine, rsp_cosine, rsp_in_range};
         results_seen++;
         if (pending_trig.size() == 0) begin
            record_failure($sformatf("unexpected beat sine %0d cosine %0d in_range %0b",
                                     got.sine, got.cosine, got.in_range));
         end else begin
            want = pending_trig.pop_front();
            if (got !== want)
               record_failure($sformatf(
                  "sine %0d/%0d cosine %0d/%0d in_range %0b/%0b (expected/actual)",
                  want.sine, got.sine, want.cosine, got.cosine,
                  want.in_range, got.in_range));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_angle = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycles = 0;
      failures = 0;
      angles_sent = 0;
      results_seen = 0;
      iter_writes = 0;
      iter_setting = ITER_RESET;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      long_hold_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fold_boundaries();
      test_iteration_counts();
      test_output_backpressure();
      test_random_stream();

      if (pending_trig.size() != 0)
         record_failure($sformatf("%0d results never arrived", pending_trig.size()));
      $display("checked %0d results for %0d angles over %0d iteration writes,",
               results_seen, angles_sent, iter_writes);
      $display("including fold boundaries, out-of-range angles and a long output stall");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", failures);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: cordic_sine_cosine_fixed.f
sv/csf_pkg.sv
sv/csf_csr.sv
sv/csf_fold.sv
sv/csf_rot_stage.sv
sv/csf_round.sv
sv/cordic_sine_cosine_fixed.sv
sv/csf_checker.sv
tb/testbench.sv
